// ----- hdl/ssct_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted symbol code table package
// Shared widths, codes, entry type and key helpers for the table core.
// ----------------------------------------------------------------------------
package ssct_pkg;

  localparam int unsigned Capacity   = 128;
  localparam int unsigned MaxSymbols = 16;

  localparam int unsigned OpW     = 2;
  localparam int unsigned KeyW    = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned LenW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 7;
  localparam int unsigned CountW  = 8;

  localparam int unsigned InW      = OpW + KeyW + CodeW + LenW;
  localparam int unsigned InBytesW = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW     = StatusW + CodeW + LenW + PosW + CountW;
  localparam int unsigned OutBytesW = ((OutW + 7) / 8) * 8;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [CodeW-1:0] bits;
    logic [LenW-1:0]  len;
  } entry_t;

  // per-cycle commands broadcast along the cell row
  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

  // handshake decisions from the sequencer
  typedef struct packed {
    logic in_ready;
    logic fire;
  } seq_ctrl_t;

  function automatic logic [KeyW-1:0] fold_upper(input logic [KeyW-1:0] c);
    logic [KeyW-1:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // signed byte order: flip the sign bit, then compare unsigned
  function automatic logic key_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
    return (a ^ 8'h80) < (b ^ 8'h80);
  endfunction

endpackage

// ----- hdl/ssct_cell.sv -----
// ----------------------------------------------------------------------------
// Table cell
// Holds one entry, compares it with the broadcast key and shifts to or from
// its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module ssct_cell
  import ssct_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,       // new command transfer, latch flags
  input  logic [KeyW-1:0] key_i,        // folded key of the incoming command
  input  logic            occ_i,        // this slot is below the fill count
  input  cell_ctrl_t      ctrl_i,
  input  entry_t          new_i,
  input  entry_t          left_i,
  input  logic            left_less_i,  // tie high on the first cell
  input  entry_t          right_i,
  output entry_t          entry_o,
  output logic            less_o,
  output logic            match_o
);

  entry_t entry_q, entry_d;
  logic   less_q, match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      less_q  <= 1'b0;
      match_q <= 1'b0;
    end else if (load_i) begin
      less_q  <= occ_i && key_less(entry_q.key, key_i);
      match_q <= occ_i && (entry_q.key == key_i);
    end
  end

  // table is sorted: cells not below the key form the tail that moves
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && !less_q) begin
      entry_d = left_less_i ? new_i : left_i;
    end else if (ctrl_i.rem_en && !less_q) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign less_o  = less_q;
  assign match_o = match_q;

endmodule

// ----- hdl/ssct_seq.sv -----
// ----------------------------------------------------------------------------
// Command sequencer
// Two-state control: take a command, then apply it once the result slot
// is free.
// ----------------------------------------------------------------------------
module ssct_seq
  import ssct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_free_i,
  output seq_ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      S_IDLE:   ctrl_o.in_ready = 1'b1;
      S_UPDATE: ctrl_o.fire     = out_free_i;
      default:  ctrl_o = '0;
    endcase
  end

endmodule

// ----- hdl/sorted_symbol_code_table_core.sv -----
// ----------------------------------------------------------------------------
// Sorted symbol code table core
// Key-sorted table of symbol code patterns built as a row of compare/shift
// cells.
// ----------------------------------------------------------------------------
// In the cycle of a command's input transfer every cell compares its key
// with the upper-cased command key, and in the update state that follows
// the row shifts one place (insert or remove) and the result is registered.
// The input side is not ready during the update state, so the table takes a
// new command only once the last one's result is registered; a result
// waiting at the output holds the update state until it is taken. Keys sort
// as signed bytes. The table is empty after reset and needs no clearing time.
module sorted_symbol_code_table_core
  import ssct_pkg::*;
#(
  parameter int unsigned CAPACITY    = Capacity,
  parameter int unsigned MAX_SYMBOLS = MaxSymbols
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // operation[1:0], character[9:2], code_bits[25:10], code_len[30:26], zero fill
  input  logic [InBytesW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[1:0], found_bits[17:2], found_len[22:18], found_position[29:23],
  // entry_count[37:30], zero fill
  output logic [OutBytesW-1:0] m_axis_tdata
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  seq_ctrl_t  seq;
  cell_ctrl_t cell_ctrl;
  logic       accept, out_free;

  // input unpacking
  logic [OpW-1:0]   in_op;
  logic [KeyW-1:0]  in_key;
  logic [CodeW-1:0] in_bits;
  logic [LenW-1:0]  in_len;
  logic [LenW:0]    len_sat;
  logic [CodeW-1:0] len_mask;

  assign in_op   = s_axis_tdata[1:0];
  assign in_key  = fold_upper(s_axis_tdata[9:2]);
  assign in_bits = s_axis_tdata[25:10];
  assign in_len  = s_axis_tdata[30:26];

  always_comb begin
    len_sat = {1'b0, in_len};
    if ({1'b0, in_len} > (LenW + 1)'(MAX_SYMBOLS)) begin
      len_sat = (LenW + 1)'(MAX_SYMBOLS);
    end
    for (int j = 0; j < CodeW; j++) begin
      len_mask[j] = ((LenW + 1)'(j) < len_sat);
    end
  end

  // command register
  logic [OpW-1:0] op_q;
  entry_t         cmd_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q       <= in_op;
      cmd_q.key  <= in_key;
      cmd_q.bits <= in_bits & len_mask;
      cmd_q.len  <= len_sat[LenW-1:0];
    end
  end

  logic [CntW-1:0] count_q, count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // cell row
  entry_t        entries [CAPACITY];
  logic [CAPACITY-1:0] less, match;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_less;

    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign left_less = 1'b1;
    end else begin : g_inner
      assign left_e    = entries[i-1];
      assign left_less = less[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    ssct_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (accept),
      .key_i       (in_key),
      .occ_i       (CntW'(i) < count_q),
      .ctrl_i      (cell_ctrl),
      .new_i       (cmd_q),
      .left_i      (left_e),
      .left_less_i (left_less),
      .right_i     (right_e),
      .entry_o     (entries[i]),
      .less_o      (less[i]),
      .match_o     (match[i])
    );
  end

  // position is the first cell not below the key; matched entry read by OR
  logic [IdxW-1:0]  pos;
  logic [CodeW-1:0] hit_bits;
  logic [LenW-1:0]  hit_len;
  logic             any_match;

  always_comb begin
    pos      = '0;
    hit_bits = '0;
    hit_len  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!less[i] && ((i == 0) || less[(i == 0) ? 0 : i - 1])) begin
        pos = pos | IdxW'(i);
      end
      if (match[i]) begin
        hit_bits = hit_bits | entries[i].bits;
        hit_len  = hit_len | entries[i].len;
      end
    end
  end

  assign any_match = |match;

  // result decision
  status_e          status;
  logic [CodeW-1:0] res_bits;
  logic [LenW-1:0]  res_len;
  logic [IdxW-1:0]  res_pos;
  logic             do_ins, do_rem;

  always_comb begin
    status   = STAT_OK;
    res_bits = '0;
    res_len  = '0;
    res_pos  = '0;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (count_q >= CntW'(CAPACITY)) begin
          status = STAT_FULL;
        end else if (any_match) begin
          status  = STAT_DUPLICATE;
          res_pos = pos;
        end else begin
          do_ins  = 1'b1;
          res_pos = pos;
        end
      end
      OP_REMOVE: begin
        if (any_match) begin
          do_rem  = 1'b1;
          res_pos = pos;
        end else begin
          status = STAT_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (any_match) begin
          res_bits = hit_bits;
          res_len  = hit_len;
          res_pos  = pos;
        end else begin
          status = STAT_NOT_FOUND;
        end
      end
      default: status = STAT_OK;
    endcase
  end

  assign cell_ctrl.ins_en = seq.fire && do_ins;
  assign cell_ctrl.rem_en = seq.fire && do_rem;

  always_comb begin
    count_d = count_q;
    if (cell_ctrl.ins_en) begin
      count_d = count_q + 1'b1;
    end else if (cell_ctrl.rem_en) begin
      count_d = count_q - 1'b1;
    end
  end

  // sequencer
  ssct_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (seq)
  );

  assign s_axis_tready = seq.in_ready;
  assign accept        = s_axis_tvalid && seq.in_ready;

  // output register
  logic                 out_valid_q;
  logic [OutBytesW-1:0] out_data_q;
  logic [31:0]          pos_wide, count_wide;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign pos_wide   = 32'(res_pos);
  assign count_wide = 32'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq.fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.fire) begin
      out_data_q <= OutBytesW'({count_wide[CountW-1:0], pos_wide[PosW-1:0],
                                res_len, res_bits, status});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- sim/sorted_symbol_code_table_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted symbol code table core testbench
// Streams insert, remove, lookup and unused-opcode commands into the table,
// keeps a shadow copy of the sorted table to predict every result transfer,
// and compares each result field by field while both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module sorted_symbol_code_table_core_test;
  import ssct_pkg::*;

  localparam logic [OpW-1:0] OpUnused      = 2'd3;
  localparam int unsigned    RandomCount   = 1950;
  localparam int unsigned    QuietTail     = 150;
  localparam int unsigned    WatchdogLimit = 2000;

  typedef struct packed {
    logic [LenW-1:0]  code_len;
    logic [CodeW-1:0] code_bits;
    logic [KeyW-1:0]  character;
    logic [OpW-1:0]   op;
  } table_cmd_t;

  typedef struct packed {
    logic [CountW-1:0]  entry_count;
    logic [PosW-1:0]    found_position;
    logic [LenW-1:0]    found_len;
    logic [CodeW-1:0]   found_bits;
    logic [StatusW-1:0] status;
  } table_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InBytesW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutBytesW-1:0] m_axis_tdata;

  sorted_symbol_code_table_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  table_cmd_t    pending_commands[$];
  table_result_t expected_results[$];
  table_cmd_t    cmd_on_bus;
  int            error_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            quiet_cycles = 0;

  // shadow of the sorted table used for prediction
  logic [KeyW-1:0]  shadow_keys  [Capacity];
  logic [CodeW-1:0] shadow_bits  [Capacity];
  logic [LenW-1:0]  shadow_lens  [Capacity];
  int               shadow_count = 0;

  // key presence tracked while the stimulus is generated
  bit gen_present [256];
  int gen_count = 0;

  function automatic logic [KeyW-1:0] upper_key(logic [KeyW-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic table_result_t table_apply(table_cmd_t cmd);
    table_result_t    r;
    logic [KeyW-1:0]  key;
    logic [CodeW-1:0] bits;
    int               len;
    int               pos;
    bit               hit;
    r = '0;
    key = upper_key(cmd.character);
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < shadow_count; i++) begin
      if (!hit && shadow_keys[i] == key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    if (cmd.op == OP_INSERT) begin
      if (shadow_count >= Capacity) begin
        r.status = STAT_FULL;
      end else if (hit) begin
        r.status = STAT_DUPLICATE;
        r.found_position = PosW'(pos);
      end else begin
        len = (cmd.code_len > MaxSymbols) ? int'(MaxSymbols) : int'(cmd.code_len);
        bits = cmd.code_bits;
        if (len < CodeW) bits = bits & ((16'd1 << len) - 16'd1);
        pos = 0;
        while (pos < shadow_count && (shadow_keys[pos] ^ 8'h80) < (key ^ 8'h80)) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_bits[i] = shadow_bits[i-1];
          shadow_lens[i] = shadow_lens[i-1];
        end
        shadow_keys[pos] = key;
        shadow_bits[pos] = bits;
        shadow_lens[pos] = LenW'(len);
        shadow_count++;
        r.status = STAT_OK;
        r.found_position = PosW'(pos);
      end
    end else if (cmd.op == OP_REMOVE) begin
      if (hit) begin
        for (int i = pos; i + 1 < shadow_count; i++) begin
          shadow_keys[i] = shadow_keys[i+1];
          shadow_bits[i] = shadow_bits[i+1];
          shadow_lens[i] = shadow_lens[i+1];
        end
        shadow_count--;
        r.status = STAT_OK;
        r.found_position = PosW'(pos);
      end else begin
        r.status = STAT_NOT_FOUND;
      end
    end else if (cmd.op == OP_LOOKUP) begin
      if (hit) begin
        r.status = STAT_OK;
        r.found_bits = shadow_bits[pos];
        r.found_len = shadow_lens[pos];
        r.found_position = PosW'(pos);
      end else begin
        r.status = STAT_NOT_FOUND;
      end
    end
    r.entry_count = CountW'(shadow_count);
    return r;
  endfunction

  function automatic void queue_command(logic [OpW-1:0] op, logic [KeyW-1:0] ch,
                                        logic [CodeW-1:0] bits, logic [LenW-1:0] len);
    table_cmd_t cmd;
    int         k;
    cmd.op = op;
    cmd.character = ch;
    cmd.code_bits = bits;
    cmd.code_len = len;
    pending_commands.push_back(cmd);
    k = int'(upper_key(ch));
    if (op == OP_INSERT && gen_count < Capacity && !gen_present[k]) begin
      gen_present[k] = 1'b1;
      gen_count++;
    end else if (op == OP_REMOVE && gen_present[k]) begin
      gen_present[k] = 1'b0;
      gen_count--;
    end
  endfunction

  // returns a key currently held, randomly in lower case where it is a letter
  function automatic logic [KeyW-1:0] pick_present_key();
    int               n;
    logic [KeyW-1:0]  k;
    n = $urandom_range(0, gen_count - 1);
    k = '0;
    for (int i = 0; i < 256; i++) begin
      if (gen_present[i]) begin
        if (n == 0) k = KeyW'(i);
        n--;
      end
    end
    if (k >= 8'h41 && k <= 8'h5A && $urandom_range(0, 1) == 1) k = k + 8'h20;
    return k;
  endfunction

  function automatic logic [KeyW-1:0] pick_absent_key();
    logic [KeyW-1:0] k;
    k = KeyW'($urandom_range(0, 255));
    while (gen_present[upper_key(k)]) k = KeyW'($urandom_range(0, 255));
    return k;
  endfunction

  function automatic logic [InBytesW-1:0] pack_command(table_cmd_t cmd);
    logic [InBytesW-1:0] word;
    word = '0;
    word[InW-1:0] = cmd;
    return word;
  endfunction

  function automatic bit quiet_tail();
    return pending_commands.size() < QuietTail;
  endfunction

  // input side: one command on the bus at a time, with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(table_apply(cmd_on_bus));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_commands.size() > 0) begin
          cmd_on_bus = pending_commands.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pack_command(cmd_on_bus);
          if (!quiet_tail() && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random stall bursts and result checks
  always @(posedge clk_i) begin
    table_result_t want;
    table_result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OutW-1:0];
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding: %h", got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
          end
          if (got.found_bits !== want.found_bits) begin
            $error("found_bits: expected %0h, got %0h", want.found_bits, got.found_bits);
            error_count++;
          end
          if (got.found_len !== want.found_len) begin
            $error("found_len: expected %0d, got %0d", want.found_len, got.found_len);
            error_count++;
          end
          if (got.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, got.found_position);
            error_count++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet_tail() && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               insert_weight;
    int               roll;
    logic [OpW-1:0]   op;
    logic [KeyW-1:0]  ch;
    int               weights [4];
    weights = '{92, 40, 10, 60};

    // empty table, folding, sign order extremes, pattern length limits
    queue_command(OP_LOOKUP, 8'h41, 16'h0000, 5'd0);
    queue_command(OP_REMOVE, 8'h00, 16'hFFFF, 5'd31);
    queue_command(OP_INSERT, 8'h61, 16'hFFFF, 5'd0);
    queue_command(OP_INSERT, 8'h41, 16'h1234, 5'd3);
    queue_command(OP_INSERT, 8'h80, 16'hFFFF, 5'd31);
    queue_command(OP_INSERT, 8'h7F, 16'hFFFF, 5'd16);
    queue_command(OP_INSERT, 8'hFF, 16'h5555, 5'd15);
    queue_command(OP_INSERT, 8'h00, 16'h0000, 5'd1);
    queue_command(OP_INSERT, 8'h7A, 16'hAAAA, 5'd17);
    queue_command(OP_INSERT, 8'h60, 16'h00F0, 5'd8);
    queue_command(OP_INSERT, 8'h7B, 16'h0F0F, 5'd12);
    queue_command(OP_LOOKUP, 8'h5A, 16'h0000, 5'd0);
    queue_command(OP_LOOKUP, 8'h80, 16'h0000, 5'd0);
    queue_command(OP_LOOKUP, 8'h7F, 16'h0000, 5'd0);
    queue_command(OP_LOOKUP, 8'h61, 16'h0000, 5'd0);
    queue_command(OP_LOOKUP, 8'hFF, 16'h0000, 5'd0);
    queue_command(OpUnused,  8'h41, 16'hFFFF, 5'd31);
    queue_command(OP_REMOVE, 8'h00, 16'h0000, 5'd0);
    queue_command(OP_REMOVE, 8'h80, 16'h0000, 5'd0);
    queue_command(OP_REMOVE, 8'h7F, 16'h0000, 5'd0);
    queue_command(OP_LOOKUP, 8'h00, 16'h0000, 5'd0);
    queue_command(OP_REMOVE, 8'h7A, 16'h0000, 5'd0);

    // phases alternate between filling and draining so the table reaches full
    insert_weight = weights[0];
    for (int n = 0; n < RandomCount; n++) begin
      if (n % 200 == 0) insert_weight = weights[(n / 200) % 4];
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OpUnused;
      end else if (roll < insert_weight) begin
        op = OP_INSERT;
      end else if (roll < insert_weight + (100 - insert_weight) / 2) begin
        op = OP_REMOVE;
      end else begin
        op = OP_LOOKUP;
      end
      if (op == OP_INSERT) begin
        ch = ($urandom_range(0, 99) < 85 && gen_count < 200) ? pick_absent_key()
                                                              : KeyW'($urandom_range(0, 255));
      end else begin
        ch = (gen_count > 0 && $urandom_range(0, 3) != 0) ? pick_present_key()
                                                          : KeyW'($urandom_range(0, 255));
      end
      queue_command(op, ch, CodeW'($urandom_range(0, 65535)), LenW'($urandom_range(0, 31)));
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_commands.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
